// ----- rtl/core/bpsa_pkg.sv -----
package bpsa_pkg;

    localparam int NUM_BLOCKS = 128;
    localparam int MAX_SLOTS  = 1024;

    localparam int BLK_W   = 7;
    localparam int SLOT_W  = 10;
    localparam int CNT_W   = 11;
    localparam int STK_W   = 8;
    localparam int RET_W   = 8;
    localparam int CAP_W   = 8;
    localparam int STAT_W  = 2;
    localparam int SADDR_W = BLK_W + 1;

    localparam logic [CNT_W-1:0] IPB_RESET      = CNT_W'(1024);
    localparam logic [CAP_W-1:0] FREE_CAP_RESET = CAP_W'(100);

    localparam logic STK_FREE  = 1'b0;
    localparam logic STK_SPARE = 1'b1;

    typedef enum logic {
        CFG_ITEMS_PER_BLOCK = 1'b0,
        CFG_FREE_CAP        = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        CMD_GET     = 1'b0,
        CMD_RELEASE = 1'b1
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK           = 2'd0,
        ST_NO_BLOCK     = 2'd1,
        ST_OVER_RELEASE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RET_RD,
        S_RET_WR,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] next_slot;
        logic [CNT_W-1:0] released;
    } t_blk_word;

    typedef struct packed {
        logic             we;
        logic [BLK_W-1:0] waddr;
        t_blk_word        wdata;
        logic             re;
        logic [BLK_W-1:0] raddr;
    } t_blk_req;

    typedef struct packed {
        logic               we;
        logic [SADDR_W-1:0] waddr;
        logic [BLK_W-1:0]   wdata;
        logic               re;
        logic [SADDR_W-1:0] raddr;
    } t_stk_req;

endpackage

// ----- rtl/core/bpsa_req_if.sv -----
interface bpsa_req_if;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [bpsa_pkg::BLK_W-1:0] block_id;

    modport source (output valid, output command, output block_id, input ready);
    modport sink (input valid, input command, input block_id, output ready);
endinterface

// ----- rtl/core/bpsa_rsp_if.sv -----
interface bpsa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [bpsa_pkg::STAT_W-1:0] status;
    logic [bpsa_pkg::BLK_W-1:0]  given_block;
    logic [bpsa_pkg::SLOT_W-1:0] given_slot;
    logic [bpsa_pkg::RET_W-1:0]  blocks_returned;

    modport source (
        output valid, output status, output given_block, output given_slot,
        output blocks_returned, input ready
    );
    modport sink (
        input valid, input status, input given_block, input given_slot,
        input blocks_returned, output ready
    );
endinterface

// ----- rtl/core/block_pool_slot_allocator.sv -----
// Slot allocator over 128 blocks with per-block handed-out and released counts.
// A get or release first reads the block counters and the top of the block
// stacks from their synchronous memories, then modifies and writes them back
// and loads the output register once it is empty. A release that pushes the
// free stack above free_cap then moves blocks to the spare pool until it is
// back at free_cap, one per cycle through the single stack memory. The next
// request is taken while a result still waits in the output register. The
// counter memory and the spare pool come out of reset ready to use, with no
// clearing pass. Configuration writes are meant for idle periods only.
module block_pool_slot_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [bpsa_pkg::CNT_W-1:0]    i_cfg_wdata,
    bpsa_req_if.sink                      i_req,
    bpsa_rsp_if.source                    o_rsp
);

    logic [bpsa_pkg::CNT_W-1:0] r_items_per_block;
    logic [bpsa_pkg::CAP_W-1:0] r_free_cap;
    logic [bpsa_pkg::CNT_W-1:0] size;

    bpsa_pkg::t_blk_req         blk_req;
    bpsa_pkg::t_blk_word        blk_rdata;
    bpsa_pkg::t_stk_req         stk_req;
    logic [bpsa_pkg::BLK_W-1:0] stk_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_items_per_block <= bpsa_pkg::IPB_RESET;
            r_free_cap        <= bpsa_pkg::FREE_CAP_RESET;
        end else if (i_cfg_we) begin
            unique case (bpsa_pkg::t_cfg_idx'(i_cfg_idx))
                bpsa_pkg::CFG_ITEMS_PER_BLOCK: r_items_per_block <= i_cfg_wdata;
                bpsa_pkg::CFG_FREE_CAP:        r_free_cap <= i_cfg_wdata[bpsa_pkg::CAP_W-1:0];
                default: ;
            endcase
        end
    end

    // effective block size, clamped to the supported range
    always_comb begin
        priority if (r_items_per_block == '0) begin
            size = bpsa_pkg::CNT_W'(1);
        end else if (r_items_per_block > bpsa_pkg::CNT_W'(bpsa_pkg::MAX_SLOTS)) begin
            size = bpsa_pkg::CNT_W'(bpsa_pkg::MAX_SLOTS);
        end else begin
            size = r_items_per_block;
        end
    end

    bpsa_blk_mem u_blk_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (blk_req),
        .o_rdata (blk_rdata)
    );

    bpsa_stk_mem u_stk_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (stk_req),
        .o_rdata (stk_rdata)
    );

    bpsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_size      (size),
        .i_free_cap  (r_free_cap),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_blk_req   (blk_req),
        .i_blk_rdata (blk_rdata),
        .o_stk_req   (stk_req),
        .i_stk_rdata (stk_rdata)
    );

endmodule

// ----- rtl/core/bpsa_blk_mem.sv -----
module bpsa_blk_mem (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bpsa_pkg::t_blk_req  i_req,
    output bpsa_pkg::t_blk_word o_rdata
);

    bpsa_pkg::t_blk_word                r_mem [bpsa_pkg::NUM_BLOCKS];
    logic [bpsa_pkg::NUM_BLOCKS-1:0]    r_vld;
    bpsa_pkg::t_blk_word                r_rdata;
    logic                               r_rd_vld;

    // unwritten entries read as zero counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.we) begin
            r_vld[i_req.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata  <= r_mem[i_req.raddr];
            r_rd_vld <= r_vld[i_req.raddr];
        end
    end

    assign o_rdata = r_rd_vld ? r_rdata : '0;

endmodule

// ----- rtl/core/bpsa_stk_mem.sv -----
module bpsa_stk_mem (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bpsa_pkg::t_stk_req           i_req,
    output logic [bpsa_pkg::BLK_W-1:0]   o_rdata
);

    localparam int DEPTH = 2 * bpsa_pkg::NUM_BLOCKS;

    logic [bpsa_pkg::BLK_W-1:0]      r_mem [DEPTH];
    logic [bpsa_pkg::NUM_BLOCKS-1:0] r_spare_vld;
    logic [bpsa_pkg::BLK_W-1:0]      r_rdata;
    logic                            r_rd_dflt;
    logic [bpsa_pkg::BLK_W-1:0]      r_rd_idx;

    // spare half starts out holding ids counting down from the last block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spare_vld <= '0;
        end else if (i_req.we && i_req.waddr[bpsa_pkg::BLK_W] == bpsa_pkg::STK_SPARE) begin
            r_spare_vld[i_req.waddr[bpsa_pkg::BLK_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata   <= r_mem[i_req.raddr];
            r_rd_idx  <= i_req.raddr[bpsa_pkg::BLK_W-1:0];
            r_rd_dflt <= (i_req.raddr[bpsa_pkg::BLK_W] == bpsa_pkg::STK_SPARE) &&
                         !r_spare_vld[i_req.raddr[bpsa_pkg::BLK_W-1:0]];
        end
    end

    assign o_rdata = r_rd_dflt ? (bpsa_pkg::BLK_W'(bpsa_pkg::NUM_BLOCKS - 1) - r_rd_idx)
                               : r_rdata;

endmodule

// ----- rtl/core/bpsa_ctrl.sv -----
module bpsa_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bpsa_pkg::CNT_W-1:0]    i_size,
    input  logic [bpsa_pkg::CAP_W-1:0]    i_free_cap,
    bpsa_req_if.sink                      i_req,
    bpsa_rsp_if.source                    o_rsp,
    output bpsa_pkg::t_blk_req            o_blk_req,
    input  bpsa_pkg::t_blk_word           i_blk_rdata,
    output bpsa_pkg::t_stk_req            o_stk_req,
    input  logic [bpsa_pkg::BLK_W-1:0]    i_stk_rdata
);

    bpsa_pkg::t_state               r_state, n_state;
    bpsa_pkg::t_cmd                 r_cmd, n_cmd;
    logic [bpsa_pkg::BLK_W-1:0]     r_bid, n_bid;
    logic [bpsa_pkg::BLK_W-1:0]     r_cur, n_cur;
    logic [bpsa_pkg::STK_W-1:0]     r_free_cnt, n_free_cnt;
    logic [bpsa_pkg::STK_W-1:0]     r_spare_cnt, n_spare_cnt;

    bpsa_pkg::t_status              r_res_status, n_res_status;
    logic [bpsa_pkg::BLK_W-1:0]     r_res_block, n_res_block;
    logic [bpsa_pkg::SLOT_W-1:0]    r_res_slot, n_res_slot;
    logic [bpsa_pkg::RET_W-1:0]     r_res_ret, n_res_ret;

    logic                           r_out_valid, n_out_valid;
    bpsa_pkg::t_status              r_out_status, n_out_status;
    logic [bpsa_pkg::BLK_W-1:0]     r_out_block, n_out_block;
    logic [bpsa_pkg::SLOT_W-1:0]    r_out_slot, n_out_slot;
    logic [bpsa_pkg::RET_W-1:0]     r_out_ret, n_out_ret;

    logic                           done;
    logic [bpsa_pkg::STK_W-1:0]     fc;
    logic [bpsa_pkg::CNT_W-1:0]     rel1;
    logic [bpsa_pkg::STK_W-1:0]     free_top;
    logic [bpsa_pkg::STK_W-1:0]     spare_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bpsa_pkg::S_IDLE;
            r_cur       <= '0;
            r_free_cnt  <= '0;
            r_spare_cnt <= bpsa_pkg::STK_W'(bpsa_pkg::NUM_BLOCKS - 1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_free_cnt  <= n_free_cnt;
            r_spare_cnt <= n_spare_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_bid        <= n_bid;
        r_res_status <= n_res_status;
        r_res_block  <= n_res_block;
        r_res_slot   <= n_res_slot;
        r_res_ret    <= n_res_ret;
        r_out_status <= n_out_status;
        r_out_block  <= n_out_block;
        r_out_slot   <= n_out_slot;
        r_out_ret    <= n_out_ret;
    end

    assign free_top  = r_free_cnt - bpsa_pkg::STK_W'(1);
    assign spare_top = r_spare_cnt - bpsa_pkg::STK_W'(1);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_bid        = r_bid;
        n_cur        = r_cur;
        n_free_cnt   = r_free_cnt;
        n_spare_cnt  = r_spare_cnt;
        n_res_status = r_res_status;
        n_res_block  = r_res_block;
        n_res_slot   = r_res_slot;
        n_res_ret    = r_res_ret;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_block  = r_out_block;
        n_out_slot   = r_out_slot;
        n_out_ret    = r_out_ret;
        o_blk_req    = '0;
        o_stk_req    = '0;
        done         = 1'b0;
        fc           = r_free_cnt;
        rel1         = i_blk_rdata.released + bpsa_pkg::CNT_W'(1);

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            bpsa_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_cmd           = bpsa_pkg::t_cmd'(i_req.command);
                    n_bid           = i_req.block_id;
                    n_res_ret       = '0;
                    o_blk_req.re    = 1'b1;
                    o_blk_req.raddr = (i_req.command == bpsa_pkg::CMD_GET) ? r_cur
                                                                           : i_req.block_id;
                    // prefetch the stack top a get might pop
                    o_stk_req.re    = 1'b1;
                    if (r_free_cnt != '0) begin
                        o_stk_req.raddr = {bpsa_pkg::STK_FREE, free_top[bpsa_pkg::BLK_W-1:0]};
                    end else begin
                        o_stk_req.raddr = {bpsa_pkg::STK_SPARE,
                                           spare_top[bpsa_pkg::BLK_W-1:0]};
                    end
                    n_state = bpsa_pkg::S_EXEC;
                end
            end
            bpsa_pkg::S_EXEC: begin
                n_res_status = bpsa_pkg::ST_OK;
                n_res_block  = '0;
                n_res_slot   = '0;
                done         = 1'b1;
                if (r_cmd == bpsa_pkg::CMD_GET) begin
                    if (i_blk_rdata.next_slot >= i_size) begin
                        o_blk_req.wdata.next_slot = bpsa_pkg::CNT_W'(1);
                        o_blk_req.wdata.released  = '0;
                        priority if (i_blk_rdata.released == i_size) begin
                            o_blk_req.we    = 1'b1;
                            o_blk_req.waddr = r_cur;
                            n_res_block     = r_cur;
                        end else if (r_free_cnt != '0) begin
                            o_blk_req.we    = 1'b1;
                            o_blk_req.waddr = i_stk_rdata;
                            n_cur           = i_stk_rdata;
                            n_free_cnt      = free_top;
                            n_res_block     = i_stk_rdata;
                        end else if (r_spare_cnt != '0) begin
                            o_blk_req.we    = 1'b1;
                            o_blk_req.waddr = i_stk_rdata;
                            n_cur           = i_stk_rdata;
                            n_spare_cnt     = spare_top;
                            n_res_block     = i_stk_rdata;
                        end else begin
                            n_res_status    = bpsa_pkg::ST_NO_BLOCK;
                        end
                    end else begin
                        o_blk_req.we              = 1'b1;
                        o_blk_req.waddr           = r_cur;
                        o_blk_req.wdata.next_slot = i_blk_rdata.next_slot +
                                                    bpsa_pkg::CNT_W'(1);
                        o_blk_req.wdata.released  = i_blk_rdata.released;
                        n_res_block               = r_cur;
                        n_res_slot = i_blk_rdata.next_slot[bpsa_pkg::SLOT_W-1:0];
                    end
                end else begin
                    if (i_blk_rdata.released >= i_size) begin
                        n_res_status = bpsa_pkg::ST_OVER_RELEASE;
                    end else begin
                        o_blk_req.we              = 1'b1;
                        o_blk_req.waddr           = r_bid;
                        o_blk_req.wdata.next_slot = i_blk_rdata.next_slot;
                        o_blk_req.wdata.released  = rel1;
                        // wholly released, not current and free stack not full: onto the free stack
                        if (r_bid != r_cur && rel1 == i_size &&
                            r_free_cnt < bpsa_pkg::STK_W'(bpsa_pkg::NUM_BLOCKS)) begin
                            o_stk_req.we    = 1'b1;
                            o_stk_req.waddr = {bpsa_pkg::STK_FREE,
                                               r_free_cnt[bpsa_pkg::BLK_W-1:0]};
                            o_stk_req.wdata = r_bid;
                            fc              = r_free_cnt + bpsa_pkg::STK_W'(1);
                        end
                        n_free_cnt = fc;
                        if (fc > i_free_cap) begin
                            done    = 1'b0;
                            n_state = bpsa_pkg::S_RET_RD;
                        end
                    end
                end
            end
            bpsa_pkg::S_RET_RD: begin
                o_stk_req.re    = 1'b1;
                o_stk_req.raddr = {bpsa_pkg::STK_FREE, free_top[bpsa_pkg::BLK_W-1:0]};
                n_state         = bpsa_pkg::S_RET_WR;
            end
            bpsa_pkg::S_RET_WR: begin
                fc         = free_top;
                n_free_cnt = fc;
                n_res_ret  = r_res_ret + bpsa_pkg::RET_W'(1);
                if (r_spare_cnt < bpsa_pkg::STK_W'(bpsa_pkg::NUM_BLOCKS)) begin
                    o_stk_req.we    = 1'b1;
                    o_stk_req.waddr = {bpsa_pkg::STK_SPARE,
                                       r_spare_cnt[bpsa_pkg::BLK_W-1:0]};
                    o_stk_req.wdata = i_stk_rdata;
                    n_spare_cnt     = r_spare_cnt + bpsa_pkg::STK_W'(1);
                end
                if (fc > i_free_cap) begin
                    o_stk_req.re    = 1'b1;
                    o_stk_req.raddr = {bpsa_pkg::STK_FREE,
                                       fc[bpsa_pkg::BLK_W-1:0] - bpsa_pkg::BLK_W'(1)};
                end else begin
                    done = 1'b1;
                end
            end
            bpsa_pkg::S_EMIT: begin
                done = 1'b1;
            end
            default: begin
                n_state = bpsa_pkg::S_IDLE;
            end
        endcase

        if (done) begin
            if (!n_out_valid) begin
                n_out_valid  = 1'b1;
                n_out_status = n_res_status;
                n_out_block  = n_res_block;
                n_out_slot   = n_res_slot;
                n_out_ret    = n_res_ret;
                n_state      = bpsa_pkg::S_IDLE;
            end else begin
                n_state = bpsa_pkg::S_EMIT;
            end
        end
    end

    assign i_req.ready           = (r_state == bpsa_pkg::S_IDLE);
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.given_block     = r_out_block;
    assign o_rsp.given_slot      = r_out_slot;
    assign o_rsp.blocks_returned = r_out_ret;

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        bpsa_pkg::t_status                status;
        logic [bpsa_pkg::BLK_W-1:0]       blk;
        logic [bpsa_pkg::SLOT_W-1:0]      slot;
        logic [bpsa_pkg::RET_W-1:0]       ret;
    } t_alloc_rsp;

    typedef enum logic {
        ROW_BEAT,
        ROW_REG
    } t_row_kind;

    typedef struct {
        t_row_kind                  kind;
        bpsa_pkg::t_cmd             cmd;
        logic [bpsa_pkg::BLK_W-1:0] blk;
        bpsa_pkg::t_cfg_idx         idx;
        int                         val;
        bit                         typed;
        t_alloc_rsp                 rsp;
    } t_dir_row;

    typedef struct {
        int ipb;
        int cap;
        int n;
        int get_pct;
    } t_phase;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic                       i_cfg_idx;
    logic [bpsa_pkg::CNT_W-1:0] i_cfg_wdata;

    bpsa_req_if req_ch();
    bpsa_rsp_if rsp_ch();

    block_pool_slot_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // pool state mirror
    logic [bpsa_pkg::CNT_W-1:0] pool_next [bpsa_pkg::NUM_BLOCKS];
    logic [bpsa_pkg::CNT_W-1:0] pool_rel [bpsa_pkg::NUM_BLOCKS];
    logic [bpsa_pkg::BLK_W-1:0] pool_free [bpsa_pkg::NUM_BLOCKS];
    logic [bpsa_pkg::BLK_W-1:0] pool_spare [bpsa_pkg::NUM_BLOCKS];
    logic [bpsa_pkg::BLK_W-1:0] pool_cur;
    int                         pool_free_n;
    int                         pool_spare_n;
    logic [bpsa_pkg::CNT_W-1:0] pool_ipb;
    logic [bpsa_pkg::CAP_W-1:0] pool_cap;

    t_alloc_rsp                 owed_replies[$];
    logic [bpsa_pkg::BLK_W-1:0] held_slots[$];
    t_dir_row                   dir_tab[$];
    int                         n_req = 0;
    int                         n_err = 0;
    bit                         tx_burst = 1'b0;

    t_phase plan [6] = '{
        '{1, 0, 70, 55},
        '{3, 2, 80, 50},
        '{1, 100, 200, 92},
        '{5, 10, 120, 35},
        '{0, 128, 60, 50},
        '{16, 4, 60, 60}
    };

    function automatic void pool_reset();
        for (int i = 0; i < bpsa_pkg::NUM_BLOCKS; i++) begin
            pool_next[i] = '0;
            pool_rel[i]  = '0;
            pool_free[i] = '0;
            pool_spare[i] = (i < bpsa_pkg::NUM_BLOCKS - 1) ?
                            bpsa_pkg::BLK_W'(bpsa_pkg::NUM_BLOCKS - 1 - i) : '0;
        end
        pool_cur     = '0;
        pool_free_n  = 0;
        pool_spare_n = bpsa_pkg::NUM_BLOCKS - 1;
        pool_ipb     = bpsa_pkg::IPB_RESET;
        pool_cap     = bpsa_pkg::FREE_CAP_RESET;
    endfunction

    function automatic t_alloc_rsp pool_apply(bpsa_pkg::t_cmd cmd,
                                              logic [bpsa_pkg::BLK_W-1:0] b);
        t_alloc_rsp                 r;
        int                         bsize;
        logic [bpsa_pkg::BLK_W-1:0] cb;
        bit                         ok;
        int                         nret;
        r = '0;
        r.status = bpsa_pkg::ST_OK;
        bsize = (pool_ipb == 0) ? 1 :
                (pool_ipb > bpsa_pkg::MAX_SLOTS) ? bpsa_pkg::MAX_SLOTS : int'(pool_ipb);
        if (cmd == bpsa_pkg::CMD_GET) begin
            cb = pool_cur;
            ok = 1'b1;
            if (int'(pool_next[cb]) >= bsize) begin
                if (int'(pool_rel[cb]) == bsize) begin
                    // wholly released, restart in place
                end else if (pool_free_n > 0) begin
                    pool_free_n--;
                    cb = pool_free[pool_free_n];
                end else if (pool_spare_n > 0) begin
                    pool_spare_n--;
                    cb = pool_spare[pool_spare_n];
                end else begin
                    ok = 1'b0;
                end
                if (ok) begin
                    pool_cur = cb;
                    pool_next[cb] = '0;
                    pool_rel[cb] = '0;
                end
            end
            if (ok) begin
                r.blk  = cb;
                r.slot = pool_next[cb][bpsa_pkg::SLOT_W-1:0];
                pool_next[cb] = pool_next[cb] + 1'b1;
            end else begin
                r.status = bpsa_pkg::ST_NO_BLOCK;
            end
        end else begin
            if (int'(pool_rel[b]) >= bsize) begin
                r.status = bpsa_pkg::ST_OVER_RELEASE;
            end else begin
                pool_rel[b] = pool_rel[b] + 1'b1;
                if (b != pool_cur && int'(pool_rel[b]) == bsize &&
                    pool_free_n < bpsa_pkg::NUM_BLOCKS) begin
                    pool_free[pool_free_n] = b;
                    pool_free_n++;
                end
                nret = 0;
                while (pool_free_n > int'(pool_cap)) begin
                    pool_free_n--;
                    if (pool_spare_n < bpsa_pkg::NUM_BLOCKS) begin
                        pool_spare[pool_spare_n] = pool_free[pool_free_n];
                        pool_spare_n++;
                    end
                    nret++;
                end
                r.ret = nret[bpsa_pkg::RET_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_dir_row beat_row(bpsa_pkg::t_cmd c, int b);
        t_dir_row row;
        row.kind  = ROW_BEAT;
        row.cmd   = c;
        row.blk   = b[bpsa_pkg::BLK_W-1:0];
        row.idx   = bpsa_pkg::CFG_ITEMS_PER_BLOCK;
        row.val   = 0;
        row.typed = 1'b0;
        row.rsp   = '0;
        return row;
    endfunction

    function automatic t_dir_row fixed_row(bpsa_pkg::t_cmd c, int b, bpsa_pkg::t_status st,
                                           int gb, int gs, int rt);
        t_dir_row row;
        row = beat_row(c, b);
        row.typed      = 1'b1;
        row.rsp.status = st;
        row.rsp.blk    = gb[bpsa_pkg::BLK_W-1:0];
        row.rsp.slot   = gs[bpsa_pkg::SLOT_W-1:0];
        row.rsp.ret    = rt[bpsa_pkg::RET_W-1:0];
        return row;
    endfunction

    function automatic t_dir_row reg_row(bpsa_pkg::t_cfg_idx i, int v);
        t_dir_row row;
        row = beat_row(bpsa_pkg::CMD_GET, 0);
        row.kind = ROW_REG;
        row.idx  = i;
        row.val  = v;
        return row;
    endfunction

    task automatic send_beat(input bpsa_pkg::t_cmd cmd, input logic [bpsa_pkg::BLK_W-1:0] b,
                             input bit typed, input t_alloc_rsp fixed);
        int         gap;
        t_alloc_rsp pred;
        gap = tx_burst ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid    <= 1'b1;
        req_ch.command  <= cmd;
        req_ch.block_id <= b;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        n_req++;
        pred = pool_apply(cmd, b);
        if (cmd == bpsa_pkg::CMD_GET && pred.status == bpsa_pkg::ST_OK) begin
            held_slots.push_back(pred.blk);
        end
        owed_replies.push_back(typed ? fixed : pred);
    endtask

    task automatic write_reg(input bpsa_pkg::t_cfg_idx idx, input int val);
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (owed_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val[bpsa_pkg::CNT_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bpsa_pkg::CFG_ITEMS_PER_BLOCK) pool_ipb = val[bpsa_pkg::CNT_W-1:0];
        else pool_cap = val[bpsa_pkg::CAP_W-1:0];
    endtask

    // reply checker
    always @(posedge i_clk) begin : chk
        t_alloc_rsp want;
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (owed_replies.size() == 0) begin
                $error("reply beat with nothing owed");
                n_err++;
            end else begin
                want = owed_replies.pop_front();
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    n_err++;
                end
                if (rsp_ch.given_block !== want.blk) begin
                    $error("given_block: expected %0d, got %0d", want.blk, rsp_ch.given_block);
                    n_err++;
                end
                if (rsp_ch.given_slot !== want.slot) begin
                    $error("given_slot: expected %0d, got %0d", want.slot, rsp_ch.given_slot);
                    n_err++;
                end
                if (rsp_ch.blocks_returned !== want.ret) begin
                    $error("blocks_returned: expected %0d, got %0d", want.ret,
                           rsp_ch.blocks_returned);
                    n_err++;
                end
            end
        end
    end

    // reply side: random back-pressure plus two long hold-offs
    initial begin : rx
        int idle_left;
        int hold_left;
        int idle_pct;
        int tick;
        int stalls_done;
        idle_left   = 0;
        hold_left   = 0;
        idle_pct    = 0;
        tick        = 0;
        stalls_done = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (tick % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    default: idle_pct = 40;
                endcase
            end
            tick++;
            if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end else if (stalls_done < 2 && n_req >= (stalls_done == 0 ? 120 : 450)) begin
                rsp_ch.ready <= 1'b0;
                hold_left = 300;
                stalls_done++;
            end else if (idle_left > 0) begin
                rsp_ch.ready <= 1'b0;
                idle_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < idle_pct) idle_left = pick_gap();
            end
        end
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stim
        int                         k;
        int                         j;
        int                         pick;
        logic [bpsa_pkg::BLK_W-1:0] b;
        req_ch.valid    = 1'b0;
        req_ch.command  = bpsa_pkg::CMD_GET;
        req_ch.block_id = '0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = bpsa_pkg::CFG_ITEMS_PER_BLOCK;
        i_cfg_wdata     = '0;
        i_rst_n         = 1'b0;
        pool_reset();

        dir_tab.push_back(fixed_row(bpsa_pkg::CMD_GET, 0, bpsa_pkg::ST_OK, 0, 0, 0));
        dir_tab.push_back(fixed_row(bpsa_pkg::CMD_GET, 127, bpsa_pkg::ST_OK, 0, 1, 0));
        dir_tab.push_back(fixed_row(bpsa_pkg::CMD_RELEASE, 127, bpsa_pkg::ST_OK, 0, 0, 0));
        dir_tab.push_back(fixed_row(bpsa_pkg::CMD_RELEASE, 0, bpsa_pkg::ST_OK, 0, 0, 0));
        dir_tab.push_back(reg_row(bpsa_pkg::CFG_ITEMS_PER_BLOCK, 1));
        // fully released current block restarts in place
        dir_tab.push_back(fixed_row(bpsa_pkg::CMD_GET, 0, bpsa_pkg::ST_OK, 0, 0, 0));
        dir_tab.push_back(beat_row(bpsa_pkg::CMD_RELEASE, 0));
        dir_tab.push_back(fixed_row(bpsa_pkg::CMD_RELEASE, 0, bpsa_pkg::ST_OVER_RELEASE,
                                    0, 0, 0));
        dir_tab.push_back(fixed_row(bpsa_pkg::CMD_RELEASE, 127, bpsa_pkg::ST_OVER_RELEASE,
                                    0, 0, 0));
        dir_tab.push_back(beat_row(bpsa_pkg::CMD_GET, 0));
        dir_tab.push_back(beat_row(bpsa_pkg::CMD_GET, 0));
        dir_tab.push_back(beat_row(bpsa_pkg::CMD_RELEASE, 0));
        dir_tab.push_back(beat_row(bpsa_pkg::CMD_GET, 0));
        dir_tab.push_back(reg_row(bpsa_pkg::CFG_FREE_CAP, 0));
        dir_tab.push_back(beat_row(bpsa_pkg::CMD_GET, 0));
        dir_tab.push_back(fixed_row(bpsa_pkg::CMD_RELEASE, 0, bpsa_pkg::ST_OK, 0, 0, 1));
        dir_tab.push_back(fixed_row(bpsa_pkg::CMD_RELEASE, 1, bpsa_pkg::ST_OK, 0, 0, 1));
        dir_tab.push_back(reg_row(bpsa_pkg::CFG_ITEMS_PER_BLOCK, 0));
        dir_tab.push_back(beat_row(bpsa_pkg::CMD_GET, 0));
        dir_tab.push_back(reg_row(bpsa_pkg::CFG_ITEMS_PER_BLOCK, 2047));
        dir_tab.push_back(beat_row(bpsa_pkg::CMD_GET, 0));
        dir_tab.push_back(beat_row(bpsa_pkg::CMD_RELEASE, 127));
        dir_tab.push_back(reg_row(bpsa_pkg::CFG_FREE_CAP, 255));
        dir_tab.push_back(beat_row(bpsa_pkg::CMD_GET, 0));

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < dir_tab.size(); k++) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            if (dir_tab[k].kind == ROW_REG) begin
                write_reg(dir_tab[k].idx, dir_tab[k].val);
            end else begin
                send_beat(dir_tab[k].cmd, dir_tab[k].blk, dir_tab[k].typed, dir_tab[k].rsp);
            end
        end

        foreach (plan[p]) begin
            write_reg(bpsa_pkg::CFG_ITEMS_PER_BLOCK, plan[p].ipb);
            write_reg(bpsa_pkg::CFG_FREE_CAP, plan[p].cap);
            tx_burst = ($urandom_range(0, 3) == 0);
            for (j = 0; j < plan[p].n; j++) begin
                if ($urandom_range(0, 99) < plan[p].get_pct) begin
                    send_beat(bpsa_pkg::CMD_GET,
                              bpsa_pkg::BLK_W'($urandom_range(0, bpsa_pkg::NUM_BLOCKS - 1)),
                              1'b0, '0);
                end else if (held_slots.size() > 0 && $urandom_range(0, 99) < 85) begin
                    pick = $urandom_range(0, held_slots.size() - 1);
                    b = held_slots[pick];
                    held_slots.delete(pick);
                    send_beat(bpsa_pkg::CMD_RELEASE, b, 1'b0, '0);
                end else begin
                    send_beat(bpsa_pkg::CMD_RELEASE,
                              bpsa_pkg::BLK_W'($urandom_range(0, bpsa_pkg::NUM_BLOCKS - 1)),
                              1'b0, '0);
                end
            end
        end

        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (owed_replies.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (n_err == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
